FILE: design/elmt_pkg.sv
// ----------------------------------------------------------------------------
// elmt_pkg
// Shared types and constants of the listener match table: action and status
// codes, sequencer states and the packed layout of one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package elmt_pkg;

   // default number of table entries
   localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

   // request actions
   typedef enum logic [1:0] {
      ACT_CONNECT    = 2'd0,
      ACT_TAKE       = 2'd1,
      ACT_DISCONNECT = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CONNECT,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   // one listener entry as stored in the table memory
   typedef struct packed {
      logic [31:0] resource;
      logic [7:0]  thread;
      logic [7:0]  mask;
   } entry_type;

   // request handed from the port side to the sequencer
   typedef struct packed {
      action_type action;
      entry_type  entry;
   } req_type;

   // result handed from the sequencer to the output register
   typedef struct packed {
      status_type  status;
      logic [7:0]  thread;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/event_listener_match_table_unit.sv
// ----------------------------------------------------------------------------
// event_listener_match_table_unit
// Ordered table of waiting listeners with connect, take and disconnect.
// ----------------------------------------------------------------------------
// The request channel (req_) carries one transaction per operation: the
// action in req_tuser and resource, thread and mask in req_tdata. Each
// transaction yields exactly one response transaction on rsp_ with status
// and the taken thread.
// A connect appends at the tail and answers full on a full table.
// A take or disconnect scans the table one entry a cycle through a single
// compare unit and, after a hit, moves the younger entries down one place a
// cycle, both through the one read port of the table memory.
// The next request is accepted in the cycle after the response is loaded,
// when the sequencer is back in idle.
// One transaction is in work at a time; req_tready is high only while the
// sequencer is idle.
// A finished response sits in an output register, so the next request is
// taken while rsp_tready is low; a further result then waits in the
// sequencer until that register frees up.
// Synchronous reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module event_listener_match_table_unit #(
   parameter int unsigned TABLE_DEPTH = elmt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // resource_handle[31:0], thread_id[39:32],
                                          // event_mask[47:40]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[1:0], taken_thread[9:2], zero[15:10]
);

   import elmt_pkg::*;

   localparam int unsigned IW = $clog2(TABLE_DEPTH);

   req_type             req;
   rsp_type             seq_rsp;
   logic                seq_idle;
   logic                seq_done;
   logic                out_free;
   logic                ram_we;
   logic [IW-1:0]       ram_waddr;
   entry_type           ram_wdata;
   logic                ram_re;
   logic [IW-1:0]       ram_raddr;
   entry_type           ram_rdata;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // unpack the request transaction
   always_comb begin
      req.action         = action_type'(req_tuser);
      req.entry.resource = req_tdata[31:0];
      req.entry.thread   = req_tdata[39:32];
      req.entry.mask     = req_tdata[47:40];
   end

   assign req_tready = seq_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   elmt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && req_tready),
      .req       (req),
      .idle      (seq_idle),
      .out_free  (out_free),
      .done      (seq_done),
      .rsp       (seq_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   elmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.thread, rsp_data_ff.status};

endmodule

`default_nettype wire

FILE: design/elmt_ram.sv
// ----------------------------------------------------------------------------
// elmt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module elmt_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/elmt_seq.sv
// ----------------------------------------------------------------------------
// elmt_seq
// Sequencer of the listener match table: appends entries, scans the table
// one entry a cycle through a single compare unit and closes the gap after
// a removal by moving younger entries down one place a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module elmt_seq #(
   parameter int unsigned TABLE_DEPTH = elmt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request side
   input  wire logic                           start,
   input  wire elmt_pkg::req_type              req,
   output logic                                idle,
   // result side
   input  wire logic                           out_free,
   output logic                                done,
   output elmt_pkg::rsp_type                   rsp,
   // table memory
   output logic                                ram_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr,
   output elmt_pkg::entry_type                 ram_wdata,
   output logic                                ram_re,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr,
   input  wire elmt_pkg::entry_type            ram_rdata
);

   import elmt_pkg::*;

   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   rsp_type          rsp_ff, rsp_in;

   logic             res_eq;
   logic             key_ok;
   logic             hit;
   logic             issue;

   // shared compare unit on the entry just read
   always_comb begin
      res_eq = (ram_rdata.resource == req_ff.entry.resource);
      if (req_ff.action == ACT_TAKE) begin
         key_ok = |(ram_rdata.mask & req_ff.entry.mask);
      end else begin
         key_ok = (ram_rdata.thread == req_ff.entry.thread);
      end
      hit   = rd_pend_ff && res_eq && key_ok;
      issue = (scan_ff < count_ff);
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
      req_ff    <= req_in;
      scan_ff   <= scan_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   // next state and memory control
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      req_in     = req_ff;
      scan_in    = scan_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = rd_idx_ff;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = count_ff[IW-1:0];
      ram_wdata  = req_ff.entry;
      ram_re     = 1'b0;
      ram_raddr  = scan_ff[IW-1:0];
      done       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req;
               scan_in       = '0;
               rsp_in.status = ST_MISS;
               rsp_in.thread = '0;
               unique case (req.action) inside
                  ACT_CONNECT:                 state_in = S_CONNECT;
                  ACT_TAKE, ACT_DISCONNECT:    state_in = S_SCAN;
                  default:                     state_in = S_DONE;
               endcase
            end
         end

         S_CONNECT: begin
            // append at the tail unless full
            if (count_ff == DEPTH_CNT) begin
               rsp_in.status = ST_FULL;
            end else begin
               ram_we        = 1'b1;
               count_in      = count_ff + 1'b1;
               rsp_in.status = ST_DONE;
            end
            state_in = S_DONE;
         end

         S_SCAN: begin
            // compare the entry read last cycle, read the next one
            if (hit) begin
               rsp_in.status = ST_DONE;
               rsp_in.thread = (req_ff.action == ACT_TAKE) ? ram_rdata.thread : '0;
               state_in      = S_SHIFT;
            end else if (!rd_pend_ff && !issue) begin
               state_in = S_DONE;
            end
            if (issue) begin
               ram_re     = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = scan_ff[IW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end

         S_SHIFT: begin
            // move each younger entry down one place
            if (rd_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (issue) begin
               ram_re     = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = scan_ff[IW-1:0];
               scan_in    = scan_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hand the result over once the output register is free
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == S_IDLE);
   assign rsp  = rsp_ff;

   // entry count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   // compaction never writes below the first entry
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && ram_we) |-> rd_idx_ff != '0)
      else $error("compaction write below entry zero");

   // end of compaction drops exactly one entry
   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && !rd_pend_ff && !issue) |=>
         count_ff == $past(count_ff) - 1'b1)
      else $error("compaction did not remove one entry");

   // a result leaves only into a free output register and the block returns idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free ##1 state_ff == S_IDLE)
      else $error("result handoff out of order");

endmodule

`default_nettype wire
